[hdl/voxel_ray_traversal_macros.svh]
// Assertion macros shared by the voxel ray traversal RTL.
`ifndef VOXEL_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_MACROS_SVH
`ifndef SYNTHESIS
`define VRT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("voxel_ray_traversal: same-cycle check failed");
`define VRT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("voxel_ray_traversal: next-cycle check failed");
`else
`define VRT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define VRT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/vrt_pkg.sv]
// Shared types, constants and helpers of the voxel ray traversal block.
package vrt_pkg;

    localparam int DEF_GRID_SIZE = 32;
    localparam int FRAC_BITS     = 8;
    localparam int T_FRAC        = 16;
    localparam int DIR_FRAC      = 14;
    localparam int T_SHIFT       = DIR_FRAC + T_FRAC - FRAC_BITS;

    localparam int VOX_IN_W = 5;
    localparam int ORG_W    = 13;
    localparam int DIR_W    = 16;
    localparam int DIST_W   = 15;
    localparam int POS_W    = 14;
    localparam int FACE_W   = 3;

    localparam int NMAG_W   = 15;
    localparam int MAG2_W   = 32;
    localparam int ROOT_W   = 24;
    localparam int NUM_W    = 38;
    localparam int DEN_W    = 24;
    localparam int T_W      = 34;
    localparam int TLIM_W   = DIST_W + T_FRAC - FRAC_BITS;
    localparam int V_W      = 10;
    localparam int PROD_W   = NMAG_W + TLIM_W;
    localparam int P_W      = 20;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 48;

    localparam logic [NMAG_W-1:0] DIR_ONE = NMAG_W'(16384);
    localparam logic [T_W-1:0]    T_INF   = T_W'(1) << (T_W - 1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        DIV_NORM   = 2'd0,
        DIV_TDELTA = 2'd1,
        DIV_TMAX   = 2'd2
    } div_op_t;

    typedef struct packed {
        logic                action;
        logic [VOX_IN_W-1:0] voxel_x;
        logic [VOX_IN_W-1:0] voxel_y;
        logic [VOX_IN_W-1:0] voxel_z;
        logic                solid_bit;
        logic [ORG_W-1:0]    origin_x;
        logic [ORG_W-1:0]    origin_y;
        logic [ORG_W-1:0]    origin_z;
        logic [DIR_W-1:0]    dir_x;
        logic [DIR_W-1:0]    dir_y;
        logic [DIR_W-1:0]    dir_z;
        logic [DIST_W-1:0]   max_dist;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  hit_x;
        logic [POS_W-1:0]  hit_y;
        logic [POS_W-1:0]  hit_z;
        logic [FACE_W-1:0] hit_face;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       clr_write;
        logic       wr_read;
        logic       wr_write;
        logic       sq_acc;
        logic       sqrt_start;
        logic       div_start;
        logic       div_store;
        div_op_t    div_op;
        logic [1:0] axis;
        logic       look;
        logic       step;
        logic       set_hit;
        logic       hit_mul;
        logic       hit_add;
        logic       emit;
    } vrt_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sqrt_idle;
        logic div_idle;
        logic t_lt_lim;
        logic solid;
        logic all_inf;
        logic out_free;
    } vrt_sts_t;

    // Magnitude of a signed direction word.
    function automatic logic [DIR_W-1:0] abs_dir(input logic signed [DIR_W-1:0] v);
        logic signed [DIR_W:0] w;
        w = {v[DIR_W-1], v};
        if (w < 0)
        begin
            w = -w;
        end
        return w[DIR_W-1:0];
    endfunction

    // Entry face code: +x 1, -x 2, +y 3, -y 4, +z 5, -z 6.
    function automatic logic [FACE_W-1:0] face_code(input logic [1:0] axis, input logic pos);
        return FACE_W'({axis, 1'b0}) + (pos ? FACE_W'(2) : FACE_W'(1));
    endfunction

endpackage

[hdl/vrt_occ_mem.sv]
// Occupancy row memory: one write port, one registered read port.
module vrt_occ_mem #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/vrt_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module vrt_div import vrt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

[hdl/vrt_datapath.sv]
// Datapath: ray registers, occupancy memory, divider, square root, walk state, hit point and result register.
module vrt_datapath import vrt_pkg::*; #(
    parameter int GRID_SIZE = DEF_GRID_SIZE
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  vrt_cmd_t  cmd,
    output vrt_sts_t  sts,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_item
);

    localparam int GW     = $clog2(GRID_SIZE);
    localparam int ROW_AW = 2 * GW;
    localparam int ROW_W  = 1 << GW;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 4;
    localparam int SQC_W  = $clog2(ROOT_W + 1);
    localparam logic signed [V_W-1:0] V_LIM   = V_W'(GRID_SIZE);
    localparam logic signed [P_W-1:0] POS_TOP = P_W'(GRID_SIZE << FRAC_BITS);

    // request registers
    logic [ORG_W-1:0]        org_reg [3];
    logic signed [DIR_W-1:0] d_reg [3];
    logic [TLIM_W-1:0]       tlim_reg;
    logic [VOX_IN_W-1:0]     wx_reg, wy_reg, wz_reg;
    logic                    solid_reg;

    // setup and walk
    logic [MAG2_W-1:0]       mag2_reg;
    logic [SQ_W-1:0]         sqv_reg;
    logic [REM_W-1:0]        srem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [SQC_W-1:0]        sqc_reg;
    logic                    sq_busy_reg;
    logic signed [DIR_W-1:0] n_reg [3];
    logic [T_W-1:0]          tdelta_reg [3];
    logic [T_W-1:0]          tmax_reg [3];
    logic [T_W-1:0]          t_reg;
    logic signed [V_W-1:0]   v_reg [3];
    logic [FACE_W-1:0]       face_reg;
    logic                    hit_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [POS_W-1:0]        hc_reg [3];
    logic [ROW_AW-1:0]       clr_cnt_reg;

    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_busy;
    logic [NUM_W-1:0]        div_quot;

    logic                    mem_we;
    logic [ROW_AW-1:0]       mem_waddr, mem_raddr;
    logic [ROW_W-1:0]        mem_wdata, mem_rdata, row_mod;

    logic [DIR_W-1:0]        a_d;
    logic [NMAG_W-1:0]       a_n;
    logic                    n_neg;
    logic [FRAC_BITS:0]      bnd_dist;
    logic [FRAC_BITS-1:0]    frac;
    logic [NMAG_W-1:0]       nm_q;
    logic signed [DIR_W-1:0] n_new;
    logic signed [2*DIR_W-1:0] sq_prod;
    logic [REM_W-1:0]        s_shift, s_trial;
    logic                    s_fits;
    logic [1:0]              sel;
    logic                    wr_ok, in_grid;
    logic [PROD_W:0]         rnd;
    logic [PROD_W-T_SHIFT:0] hmag;
    logic signed [P_W-1:0]   p_raw, p_sat;

    assign a_d      = abs_dir(d_reg[cmd.axis]);
    assign n_neg    = n_reg[cmd.axis][DIR_W-1];
    assign a_n      = NMAG_W'(abs_dir(n_reg[cmd.axis]));
    assign frac     = org_reg[cmd.axis][FRAC_BITS-1:0];
    assign bnd_dist = n_neg ? {1'b0, frac} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frac};

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        case (cmd.div_op)
            DIV_NORM:
            begin
                div_num = {a_d, 22'd0} + NUM_W'(root_reg >> 1);
                div_den = root_reg;
            end
            DIV_TDELTA:
            begin
                div_num = NUM_W'(1) << (DIR_FRAC + T_FRAC);
                div_den = DEN_W'(a_n);
            end
            DIV_TMAX:
            begin
                div_num = NUM_W'(bnd_dist) << T_SHIFT;
                div_den = DEN_W'(a_n);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    vrt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // clamp and sign the normalized component
    assign nm_q  = (div_quot > NUM_W'(DIR_ONE)) ? DIR_ONE : div_quot[NMAG_W-1:0];
    assign n_new = (root_reg == '0) ? '0 :
                   (d_reg[cmd.axis][DIR_W-1] ? -$signed({1'b0, nm_q}) : $signed({1'b0, nm_q}));

    assign sq_prod = d_reg[cmd.axis] * d_reg[cmd.axis];

    // one root digit per cycle
    assign s_shift = {srem_reg[REM_W-3:0], sqv_reg[SQ_W-1 -: 2]};
    assign s_trial = REM_W'({root_reg, 2'b01});
    assign s_fits  = s_shift >= s_trial;

    // axis with the nearest boundary; later axes win ties
    always_comb
    begin
        if ((tmax_reg[0] < tmax_reg[1]) && (tmax_reg[0] < tmax_reg[2]))
        begin
            sel = AXIS_X;
        end
        else if (tmax_reg[1] < tmax_reg[2])
        begin
            sel = AXIS_Y;
        end
        else
        begin
            sel = AXIS_Z;
        end
    end

    assign wr_ok   = (32'(wx_reg) < GRID_SIZE) && (32'(wy_reg) < GRID_SIZE)
                  && (32'(wz_reg) < GRID_SIZE);
    assign in_grid = (v_reg[0] >= 0) && (v_reg[0] < V_LIM) && (v_reg[1] >= 0)
                  && (v_reg[1] < V_LIM) && (v_reg[2] >= 0) && (v_reg[2] < V_LIM);

    always_comb
    begin
        row_mod = mem_rdata;
        row_mod[GW'(wx_reg)] = solid_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {GW'(wz_reg), GW'(wy_reg)};
        mem_wdata = row_mod;
        if (cmd.clr_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.wr_write)
        begin
            mem_we = wr_ok;
        end
    end

    assign mem_raddr = cmd.look ? {v_reg[2][GW-1:0], v_reg[1][GW-1:0]}
                                : {GW'(wz_reg), GW'(wy_reg)};

    vrt_occ_mem #(
        .ADDR_W (ROW_AW),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // rounded hit offset, added to or subtracted from the origin by the ray's sign and clamped to the grid
    assign rnd   = {1'b0, prod_reg} + (PROD_W+1)'(1 << (T_SHIFT - 1));
    assign hmag  = rnd[PROD_W:T_SHIFT];
    assign p_raw = n_neg ? $signed(P_W'(org_reg[cmd.axis])) - $signed(P_W'(hmag))
                         : $signed(P_W'(org_reg[cmd.axis])) + $signed(P_W'(hmag));
    assign p_sat = (p_raw < 0) ? '0 : ((p_raw > POS_TOP) ? POS_TOP : p_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            sq_busy_reg   <= 1'b0;
            sqc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_AW'(1);
            end
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sqc_reg     <= SQC_W'(ROOT_W);
            end
            else if (sq_busy_reg)
            begin
                sqc_reg <= sqc_reg - SQC_W'(1);
                if (sqc_reg == SQC_W'(1))
                begin
                    sq_busy_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            org_reg[0] <= item.origin_x;
            org_reg[1] <= item.origin_y;
            org_reg[2] <= item.origin_z;
            d_reg[0]   <= item.dir_x;
            d_reg[1]   <= item.dir_y;
            d_reg[2]   <= item.dir_z;
            v_reg[0]   <= V_W'(item.origin_x >> FRAC_BITS);
            v_reg[1]   <= V_W'(item.origin_y >> FRAC_BITS);
            v_reg[2]   <= V_W'(item.origin_z >> FRAC_BITS);
            tlim_reg   <= TLIM_W'(item.max_dist) << (T_FRAC - FRAC_BITS);
            wx_reg     <= item.voxel_x;
            wy_reg     <= item.voxel_y;
            wz_reg     <= item.voxel_z;
            solid_reg  <= item.solid_bit;
            t_reg      <= '0;
            face_reg   <= '0;
            hit_reg    <= 1'b0;
        end
        if (cmd.sq_acc)
        begin
            mag2_reg <= ((cmd.axis == AXIS_X) ? '0 : mag2_reg) + MAG2_W'(sq_prod);
        end
        if (cmd.sqrt_start)
        begin
            sqv_reg  <= {mag2_reg, 16'd0};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sqv_reg  <= sqv_reg << 2;
            srem_reg <= s_fits ? s_shift - s_trial : s_shift;
            root_reg <= {root_reg[ROOT_W-2:0], s_fits};
        end
        if (cmd.div_store)
        begin
            case (cmd.div_op)
                DIV_NORM:   n_reg[cmd.axis]      <= n_new;
                DIV_TDELTA: tdelta_reg[cmd.axis] <= div_quot[T_W-1:0];
                DIV_TMAX:   tmax_reg[cmd.axis]   <= (a_n == '0) ? T_INF : div_quot[T_W-1:0];
                default:    tmax_reg[cmd.axis]   <= T_INF;
            endcase
        end
        if (cmd.step)
        begin
            t_reg           <= tmax_reg[sel];
            tmax_reg[sel]   <= tmax_reg[sel] + tdelta_reg[sel];
            v_reg[sel]      <= n_reg[sel][DIR_W-1] ? v_reg[sel] - V_W'(1)
                                                   : v_reg[sel] + V_W'(1);
            face_reg        <= face_code(sel, !n_reg[sel][DIR_W-1]);
        end
        if (cmd.set_hit)
        begin
            hit_reg <= 1'b1;
        end
        if (cmd.hit_mul)
        begin
            prod_reg <= PROD_W'(a_n) * PROD_W'(t_reg[TLIM_W-1:0]);
        end
        if (cmd.hit_add)
        begin
            hc_reg[cmd.axis] <= p_sat[POS_W-1:0];
        end
        if (cmd.emit)
        begin
            out_reg.hit      <= hit_reg;
            out_reg.hit_x    <= hit_reg ? hc_reg[0] : '0;
            out_reg.hit_y    <= hit_reg ? hc_reg[1] : '0;
            out_reg.hit_z    <= hit_reg ? hc_reg[2] : '0;
            out_reg.hit_face <= hit_reg ? face_reg : '0;
        end
    end

    assign sts.clr_last  = &clr_cnt_reg;
    assign sts.sqrt_idle = !sq_busy_reg;
    assign sts.div_idle  = !div_busy;
    assign sts.t_lt_lim  = t_reg < T_W'(tlim_reg);
    assign sts.solid     = mem_rdata[v_reg[0][GW-1:0]] && in_grid;
    assign sts.all_inf   = tmax_reg[0][T_W-1] && tmax_reg[1][T_W-1] && tmax_reg[2][T_W-1];
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[hdl/vrt_ctrl.sv]
// Controller: sequences clearing, voxel writes, ray setup, the walk and the result.
module vrt_ctrl import vrt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_action,
    output logic     in_ready,
    input  vrt_sts_t sts,
    output vrt_cmd_t cmd
);

    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_WR_RD   = 14'b00000000000100,
        ST_WR_WB   = 14'b00000000001000,
        ST_MAG     = 14'b00000000010000,
        ST_SQRT    = 14'b00000000100000,
        ST_NORM    = 14'b00000001000000,
        ST_TDELTA  = 14'b00000010000000,
        ST_TMAX    = 14'b00000100000000,
        ST_CHECK   = 14'b00001000000000,
        ST_LOOK    = 14'b00010000000000,
        ST_HIT_MUL = 14'b00100000000000,
        ST_HIT_ADD = 14'b01000000000000,
        ST_EMIT    = 14'b10000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       go_reg, go_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            axis_reg  <= AXIS_X;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            go_reg    <= go_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        go_next    = 1'b0;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = in_action ? ST_MAG : ST_WR_RD;
                end
            end
            ST_WR_RD:
            begin
                cmd.wr_read = 1'b1;
                state_next  = ST_WR_WB;
            end
            ST_WR_WB:
            begin
                cmd.wr_write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_MAG:
            begin
                cmd.sq_acc = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_SQRT;
                    go_next    = 1'b1;
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                if (go_reg)
                begin
                    cmd.sqrt_start = 1'b1;
                end
                else if (sts.sqrt_idle)
                begin
                    state_next = ST_NORM;
                    axis_next  = AXIS_X;
                    go_next    = 1'b1;
                end
            end
            ST_NORM, ST_TDELTA, ST_TMAX:
            begin
                cmd.div_op = (state_reg == ST_NORM) ? DIV_NORM :
                             ((state_reg == ST_TDELTA) ? DIV_TDELTA : DIV_TMAX);
                if (go_reg)
                begin
                    cmd.div_start = 1'b1;
                end
                else if (sts.div_idle)
                begin
                    cmd.div_store = 1'b1;
                    go_next       = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        axis_next  = AXIS_X;
                        state_next = (state_reg == ST_NORM)   ? ST_TDELTA :
                                     ((state_reg == ST_TDELTA) ? ST_TMAX : ST_CHECK);
                    end
                    else
                    begin
                        axis_next = axis_reg + 2'd1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.t_lt_lim)
                begin
                    cmd.look   = 1'b1;
                    state_next = ST_LOOK;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LOOK:
            begin
                if (sts.solid)
                begin
                    cmd.set_hit = 1'b1;
                    axis_next   = AXIS_X;
                    state_next  = ST_HIT_MUL;
                end
                else if (sts.all_inf)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_HIT_MUL:
            begin
                cmd.hit_mul = 1'b1;
                state_next  = ST_HIT_ADD;
            end
            ST_HIT_ADD:
            begin
                cmd.hit_add = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_HIT_MUL;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/voxel_ray_traversal.sv]
// Top level of the voxel occupancy grid with DDA ray casting.
//
// Usage:
//   s_axis carries one request per transfer. tuser selects the kind: 0 writes
//   one voxel (set or clear), 1 casts a ray. A write gives no result; a ray
//   gives exactly one result on m_axis (hit flag, hit point, entry face).
//   A write reads its occupancy row and writes it back, then the block is ready
//   again. A ray accumulates the squared length per axis, takes the square root,
//   then runs nine divisions on the single shared divider (normalize, tDelta,
//   first tMax per axis), reads one occupancy row per voxel visited, and works
//   out the hit point one axis at a time.
//   One request is worked on at a time; s_axis_tready is high only while idle.
//   After reset the occupancy memory is swept clear one row per cycle, with
//   tready low.
//   The result sits in an output register; when m_axis stalls the block still
//   takes the next request and holds its own result until the register frees.
module voxel_ray_traversal import vrt_pkg::*; #(
    parameter int GRID_SIZE = DEF_GRID_SIZE
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // voxel_x, voxel_y, voxel_z, solid_bit, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, max_dist, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit, hit_x, hit_y, hit_z, hit_face, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

`include "voxel_ray_traversal_macros.svh"

    in_item_t  item;
    out_item_t res;
    vrt_cmd_t  cmd;
    vrt_sts_t  sts;

    // unpack the request fields, lowest bit first
    assign item.action    = s_axis_tuser;
    assign item.voxel_x   = s_axis_tdata[4:0];
    assign item.voxel_y   = s_axis_tdata[9:5];
    assign item.voxel_z   = s_axis_tdata[14:10];
    assign item.solid_bit = s_axis_tdata[15];
    assign item.origin_x  = s_axis_tdata[28:16];
    assign item.origin_y  = s_axis_tdata[41:29];
    assign item.origin_z  = s_axis_tdata[54:42];
    assign item.dir_x     = s_axis_tdata[70:55];
    assign item.dir_y     = s_axis_tdata[86:71];
    assign item.dir_z     = s_axis_tdata[102:87];
    assign item.max_dist  = s_axis_tdata[117:103];

    vrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vrt_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_item  (res)
    );

    // pack the result, hit flag in bit 0
    assign m_axis_tdata = {2'b00, res.hit_face, res.hit_z, res.hit_y, res.hit_x, res.hit};

    // a taken request always leaves the idle state in the cycle after it is taken
    `VRT_ASSERT_NXT(a_ready_drops, clk, rst_n, (s_axis_tvalid && s_axis_tready), !s_axis_tready)
    // never load a result over one that the receiver has not taken
    `VRT_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, (!m_axis_tvalid || m_axis_tready))
    // a result shows up only after the controller emitted it
    `VRT_ASSERT_IMP(a_valid_from_emit, clk, rst_n, $rose(m_axis_tvalid), $past(cmd.emit))

endmodule

[test/tb_voxel_ray_traversal.sv]
// Self-checking testbench of the voxel ray traversal block.
`timescale 1ns / 1ps

module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    localparam int GRID        = 32;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_ITEMS  = 730;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 450;
    localparam int HOLD_AT     = 200;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RAY   = 1'b1;

    localparam logic [FACE_W-1:0] FACE_NONE = 3'd0;

    localparam longint unsigned T_INFINITE = 64'd1 << 62;

    // One row of the directed table; check_now marks rows whose result is typed in.
    typedef struct {
        in_item_t  req;
        logic      check_now;
        out_item_t want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow occupancy grid, updated when a write request is accepted.
    bit        occ_shadow [GRID*GRID*GRID];
    out_item_t ray_results [$];
    dir_row_t  dir_rows [$];

    int  errors;
    int  cycles;
    int  rays_sent;
    int  writes_sent;
    int  hits_seen;
    int  results_seen;
    bit  calm;

    voxel_ray_traversal dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Walk the grid the way the block should: normalize, set up DDA, step.
    function automatic out_item_t cast_ray(input in_item_t r);
        longint unsigned org [3];
        longint unsigned tdel [3];
        longint unsigned tmx [3];
        longint unsigned mag2, rem, root, bitv, t, tlim, a, q, bnd, mag;
        longint signed   dd [3];
        longint signed   nn [3];
        longint signed   p;
        int              stp [3];
        int              vx [3];
        int              ax;
        int              face;
        out_item_t       res;
        org[0] = r.origin_x;
        org[1] = r.origin_y;
        org[2] = r.origin_z;
        dd[0]  = $signed(r.dir_x);
        dd[1]  = $signed(r.dir_y);
        dd[2]  = $signed(r.dir_z);
        for (int i = 0; i < 3; i++)
        begin
            vx[i] = int'(org[i] >> FRAC_BITS);
        end
        tlim = longint'(r.max_dist) << (T_FRAC - FRAC_BITS);
        mag2 = longint'(dd[0] * dd[0] + dd[1] * dd[1] + dd[2] * dd[2]) << 16;
        // Integer square root, bit by bit.
        rem  = mag2;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (root == 0)
            begin
                nn[i] = 0;
            end
            else
            begin
                a = (dd[i] < 0) ? longint'(-dd[i]) : longint'(dd[i]);
                q = ((a << 22) + (root >> 1)) / root;
                if (q > 16384)
                begin
                    q = 16384;
                end
                nn[i] = (dd[i] < 0) ? -longint'(q) : longint'(q);
            end
            stp[i] = (nn[i] >= 0) ? 1 : -1;
            if (nn[i] == 0)
            begin
                tdel[i] = T_INFINITE;
                tmx[i]  = T_INFINITE;
            end
            else
            begin
                a       = (nn[i] < 0) ? longint'(-nn[i]) : longint'(nn[i]);
                bnd     = (nn[i] > 0) ? (256 - (org[i] & 255)) : (org[i] & 255);
                tdel[i] = (64'd1 << (DIR_FRAC + T_FRAC)) / a;
                tmx[i]  = (bnd << T_SHIFT) / a;
            end
        end
        res  = '0;
        t    = 0;
        face = 0;
        while (t < tlim)
        begin
            if (vx[0] >= 0 && vx[1] >= 0 && vx[2] >= 0 && vx[0] < GRID && vx[1] < GRID
                && vx[2] < GRID && occ_shadow[vx[0] + GRID * (vx[1] + GRID * vx[2])])
            begin
                res.hit = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    a   = (nn[i] < 0) ? longint'(-nn[i]) : longint'(nn[i]);
                    mag = (a * t + (64'd1 << (T_SHIFT - 1))) >> T_SHIFT;
                    p   = longint'(org[i]) + ((nn[i] < 0) ? -longint'(mag) : longint'(mag));
                    if (p < 0)
                    begin
                        p = 0;
                    end
                    if (p > GRID * 256)
                    begin
                        p = GRID * 256;
                    end
                    if (i == 0)
                    begin
                        res.hit_x = POS_W'(p);
                    end
                    else if (i == 1)
                    begin
                        res.hit_y = POS_W'(p);
                    end
                    else
                    begin
                        res.hit_z = POS_W'(p);
                    end
                end
                res.hit_face = FACE_W'(face);
                return res;
            end
            if (tmx[0] == T_INFINITE && tmx[1] == T_INFINITE && tmx[2] == T_INFINITE)
            begin
                break;
            end
            // Ties go to the later axis: y over x, z over y.
            if (tmx[0] < tmx[1] && tmx[0] < tmx[2])
            begin
                ax = 0;
            end
            else if (tmx[1] < tmx[2])
            begin
                ax = 1;
            end
            else
            begin
                ax = 2;
            end
            t       = tmx[ax];
            vx[ax]  = vx[ax] + stp[ax];
            tmx[ax] = tmx[ax] + tdel[ax];
            face    = 2 * ax + ((stp[ax] > 0) ? 2 : 1);
        end
        return res;
    endfunction

    function automatic in_item_t write_req(input int x, input int y, input int z,
                                           input logic solid);
        in_item_t r;
        r           = '0;
        r.action    = ACT_WRITE;
        r.voxel_x   = VOX_IN_W'(x);
        r.voxel_y   = VOX_IN_W'(y);
        r.voxel_z   = VOX_IN_W'(z);
        r.solid_bit = solid;
        // Ray fields ride along as noise; the block must ignore them.
        r.origin_x  = ORG_W'($urandom);
        r.dir_y     = DIR_W'($urandom);
        r.max_dist  = DIST_W'($urandom);
        return r;
    endfunction

    function automatic in_item_t ray_req(input int ox, input int oy, input int oz,
                                         input int dx, input int dy, input int dz,
                                         input int dmax);
        in_item_t r;
        r          = '0;
        r.action   = ACT_RAY;
        r.origin_x = ORG_W'(ox);
        r.origin_y = ORG_W'(oy);
        r.origin_z = ORG_W'(oz);
        r.dir_x    = DIR_W'(dx);
        r.dir_y    = DIR_W'(dy);
        r.dir_z    = DIR_W'(dz);
        r.max_dist = DIST_W'(dmax);
        // Write fields ride along as noise.
        r.voxel_x  = VOX_IN_W'($urandom);
        r.solid_bit = 1'(($urandom));
        return r;
    endfunction

    function automatic dir_row_t row(input in_item_t r);
        dir_row_t d;
        d.req       = r;
        d.check_now = 1'b0;
        d.want      = '0;
        return d;
    endfunction

    function automatic dir_row_t row_known(input in_item_t r, input out_item_t w);
        dir_row_t d;
        d.req       = r;
        d.check_now = 1'b1;
        d.want      = w;
        return d;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(input dir_row_t d);
        dir_rows.insert(dir_rows.size(), d);
    endtask

    task automatic report(input string what, input int got, input int want);
        errors = errors + 1;
        $display("result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // Drive one request after random gaps (none when calm), holding it until the block takes it; leave tvalid high.
    task automatic push_request(input in_item_t r, input bit has_want, input out_item_t w);
        while (!calm && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {2'b00, r.max_dist, r.dir_z, r.dir_y, r.dir_x, r.origin_z,
                          r.origin_y, r.origin_x, r.solid_bit, r.voxel_z, r.voxel_y,
                          r.voxel_x};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (r.action == ACT_WRITE)
        begin
            writes_sent = writes_sent + 1;
            occ_shadow[int'(r.voxel_x) + GRID * (int'(r.voxel_y) + GRID * int'(r.voxel_z))]
                = r.solid_bit;
        end
        else
        begin
            rays_sent = rays_sent + 1;
            ray_results.insert(ray_results.size(), has_want ? w : cast_ray(r));
        end
    endtask

    // Random ray: mostly aimed around the busy middle of the grid, short reach.
    function automatic in_item_t random_ray();
        int ox, oy, oz, dx, dy, dz, dm, sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            ox = $urandom_range(20 * 256, 2 * 256);
            oy = $urandom_range(20 * 256, 2 * 256);
            oz = $urandom_range(20 * 256, 2 * 256);
        end
        else
        begin
            ox = $urandom_range(8191);
            oy = $urandom_range(8191);
            oz = $urandom_range(8191);
        end
        dx = int'($urandom_range(32768)) - 16384;
        dy = int'($urandom_range(32768)) - 16384;
        dz = int'($urandom_range(32768)) - 16384;
        if (sel % 10 == 0)
        begin
            dx = 0;
            dy = 0;
            dz = 0;
        end
        else if (sel % 10 == 1)
        begin
            dy = 0;
            dz = 0;
        end
        else if (sel % 10 == 2)
        begin
            dx = dz;
            dy = dz;
        end
        if ($urandom_range(9) == 0)
        begin
            dm = $urandom_range(16384);
        end
        else
        begin
            dm = $urandom_range(3072);
        end
        return ray_req(ox, oy, oz, dx, dy, dz, dm);
    endfunction

    // Stimulus.
    initial
    begin
        out_item_t none;
        out_item_t at_origin;
        in_item_t  r;
        errors        = 0;
        rays_sent     = 0;
        writes_sent   = 0;
        hits_seen     = 0;
        results_seen  = 0;
        calm          = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        rst_n         = 1'b0;
        none          = '0;
        at_origin     = '0;
        at_origin.hit   = 1'b1;
        at_origin.hit_x = POS_W'(128);
        at_origin.hit_y = POS_W'(128);
        at_origin.hit_z = POS_W'(128);
        at_origin.hit_face = FACE_NONE;

        // Empty grid, zero reach and zero direction: plain misses.
        add_row(row_known(ray_req(128, 128, 128, 16384, 0, 0, 0), none));
        add_row(row_known(ray_req(128, 128, 128, 0, 0, 0, 16384), none));
        add_row(row(write_req(0, 0, 0, 1'b1)));
        // Solid start voxel: hit at the origin with no face; zero reach still misses.
        add_row(row_known(ray_req(128, 128, 128, 0, 0, 0, 256), at_origin));
        add_row(row_known(ray_req(128, 128, 128, 0, 16384, 0, 0), none));
        add_row(row_known(ray_req(128, 128, 128, -16384, 0, 0, 16384), at_origin));
        add_row(row(write_req(31, 31, 31, 1'b1)));
        add_row(row(write_req(5, 5, 5, 1'b1)));
        // Axis-aligned shots at voxel (5,5,5) along +x, -x, +y and -z.
        add_row(row(ray_req(384, 1408, 1408, 16384, 0, 0, 16384)));
        add_row(row(ray_req(2816, 1408, 1408, -16384, 0, 0, 16384)));
        add_row(row(ray_req(1408, 384, 1408, 0, 16384, 0, 16384)));
        add_row(row(ray_req(1408, 1408, 8191, 0, 0, -16384, 16384)));
        // Zero fraction with a negative step leaves the start voxel at once.
        add_row(row(ray_req(1536, 1280, 1280, -16384, 0, 0, 512)));
        // Three-way tie on the diagonal, and the far corner at full reach.
        add_row(row(ray_req(128, 128, 128, 16384, 16384, 16384, 16384)));
        add_row(row(ray_req(7000, 7000, 7000, 16384, 16384, 16384, 16384)));
        add_row(row(ray_req(8191, 8191, 8191, -16384, -16384, -16384, 16384)));
        add_row(row(ray_req(0, 0, 0, 1, -1, 1, 16384)));
        // Walk out of the grid and keep going through empty space.
        add_row(row(ray_req(8191, 4000, 0, 16384, -3000, -16384, 16384)));
        // Clear a voxel and shoot through where it was.
        add_row(row(write_req(5, 5, 5, 1'b0)));
        add_row(row(ray_req(384, 1408, 1408, 16384, 0, 0, 16384)));
        add_row(row(ray_req(384, 1408, 1408, 16384, 0, 0, 16383)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (dir_rows[k])
        begin
            push_request(dir_rows[k].req, dir_rows[k].check_now, dir_rows[k].want);
        end

        // Random part: writes bias toward a dense cluster so rays find hits.
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            calm = (k >= CALM_FIRST && k < CALM_LAST);
            if (k == HOLD_AT)
            begin
                // Hold off until every outstanding result has drained.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (ray_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            if ($urandom_range(99) < 40)
            begin
                if ($urandom_range(99) < 70)
                begin
                    r = write_req($urandom_range(15, 6), $urandom_range(15, 6),
                                  $urandom_range(15, 6), 1'($urandom_range(99) < 80));
                end
                else
                begin
                    r = write_req($urandom_range(31), $urandom_range(31),
                                  $urandom_range(31), 1'($urandom_range(99) < 60));
                end
            end
            else
            begin
                r = random_ray();
            end
            push_request(r, 1'b0, none);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (ray_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (ray_results.size() != 0)
        begin
            report("results left over", ray_results.size(), 0);
        end
        $display("covered %0d voxel writes and %0d rays, %0d of them hits",
                 writes_sent, rays_sent, hits_seen);
        $display("directed extremes, ties, empty-grid walks and random DDA walks done");
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls, none during the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen = results_seen + 1;
            if (ray_results.size() == 0)
            begin
                report("result with nothing pending", 1, 0);
            end
            else
            begin
                want = ray_results.pop_front();
                if (m_axis_tdata[0])
                begin
                    hits_seen = hits_seen + 1;
                end
                if (m_axis_tdata[0] !== want.hit)
                begin
                    report("hit", m_axis_tdata[0], want.hit);
                end
                if (m_axis_tdata[14:1] !== want.hit_x)
                begin
                    report("hit_x", m_axis_tdata[14:1], want.hit_x);
                end
                if (m_axis_tdata[28:15] !== want.hit_y)
                begin
                    report("hit_y", m_axis_tdata[28:15], want.hit_y);
                end
                if (m_axis_tdata[42:29] !== want.hit_z)
                begin
                    report("hit_z", m_axis_tdata[42:29], want.hit_z);
                end
                if (m_axis_tdata[45:43] !== want.hit_face)
                begin
                    report("hit_face", m_axis_tdata[45:43], want.hit_face);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
